// ===== design/mcbp_pkg.sv =====
package mcbp_pkg;

	// Per-CPU table geometry and the bank limit.
	localparam int CPU_SLOTS = 256;
	localparam int SLOT_W    = $clog2(CPU_SLOTS);
	localparam int MAX_BANKS = 64;

	// Field widths.
	localparam int CMD_W     = 2;
	localparam int CPU_W     = 8;
	localparam int TS_W      = 64;
	localparam int BANK_W    = 6;
	localparam int BCNT_W    = 7;
	localparam int GAP_W     = 40;
	localparam int WORD_W    = 64;
	localparam int CNT_W     = 32;
	localparam int ACT_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 40;

	// Status word bits.
	localparam int ST_VALID_BIT = 63;
	localparam int ST_OVER_BIT  = 62;
	localparam int ST_UC_BIT    = 61;
	localparam int ST_ADDRV_BIT = 58;

	// Stream data widths, padded to whole bytes.
	localparam int IN_RAW_W  = CMD_W + CPU_W + TS_W + BANK_W + 2 * WORD_W;
	localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W = ACT_W + 2 * CNT_W + 1 + BANK_W + 2 * WORD_W + 2;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN  = 2'd0,
		CMD_POLL   = 2'd1,
		CMD_REPORT = 2'd2
	} cmd_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE   = 3'd0,
		ACT_CLRALL = 3'd1,
		ACT_SKIP   = 3'd2,
		ACT_SCAN   = 3'd3,
		ACT_CLR1   = 3'd4
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MCA      = 2'd0,
		CFG_BANKS    = 2'd1,
		CFG_THROTTLE = 2'd2,
		CFG_GAP      = 2'd3
	} cfg_idx_t;

	// Write request into the per-CPU table.
	typedef struct packed {
		logic              write;
		logic              clear_all;
		logic [SLOT_W-1:0] addr;
		logic [TS_W-1:0]   data;
	} tbl_wr_t;

	// Read result of the per-CPU table, registered and available in the cycle after the read.
	typedef struct packed {
		logic            baselined;
		logic [TS_W-1:0] last_poll;
	} tbl_rd_t;

	// Update of the run counters and last-event record.
	typedef struct packed {
		logic              clear;
		logic              capture;
		logic              uncorr;
		logic              over;
		logic [BANK_W-1:0] bank;
		logic [WORD_W-1:0] status;
		logic [WORD_W-1:0] addr;
	} evt_upd_t;

	typedef struct packed {
		logic [CNT_W-1:0]  corr_cnt;
		logic [CNT_W-1:0]  uncorr_cnt;
		logic              captured;
		logic [BANK_W-1:0] bank;
		logic [WORD_W-1:0] status;
		logic [WORD_W-1:0] addr;
		logic              corr;
		logic              over;
	} evt_rec_t;

endpackage

// ===== design/machine_check_bank_poller_top.sv =====
// Channel    Direction  Handshake            Payload
// s_tdata    in         s_tvalid / s_tready  request: cmd, cpu_id, now, bank, status, addr
// m_tdata    out        m_tvalid / m_tready  result: action, counts, last event
// cfg        in         cfg_we               cfg_index, cfg_data (no read-back)
//
// Each request first reads the per-CPU poll table, then decides, writes the
// table back and loads the output register; a new request is taken only once
// the current one has finished.
// A waiting result does not block the table read, but the decision step holds
// until the output register is free.
// Reset clears control state, counters and every baselined mark at once.
module machine_check_bank_poller_top
	import mcbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Fields from bit 0 up: cmd, cpu_id, now, bank, bank_status, bank_addr, zero pad.
	input  logic [IN_W-1:0]      s_tdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// Fields from bit 0 up: action, corrected_count, uncorrected_count, has_last,
	// last_bank, last_status, last_addr, last_corrected, last_overflow, zero pad.
	output logic [OUT_W-1:0]     m_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Input field offsets.
	localparam int IN_CPU  = CMD_W;
	localparam int IN_NOW  = IN_CPU + CPU_W;
	localparam int IN_BANK = IN_NOW + TS_W;
	localparam int IN_ST   = IN_BANK + BANK_W;
	localparam int IN_ADDR = IN_ST + WORD_W;

	// Configuration registers.
	logic              mca_q;
	logic [BCNT_W-1:0] bank_cnt_q;
	logic              throttle_q;
	logic [GAP_W-1:0]  gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mca_q      <= 1'b0;
			bank_cnt_q <= BCNT_W'(1);
			throttle_q <= 1'b0;
			gap_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MCA:      mca_q      <= cfg_data[0];
				CFG_BANKS:    bank_cnt_q <= cfg_data[BCNT_W-1:0];
				CFG_THROTTLE: throttle_q <= cfg_data[0];
				CFG_GAP:      gap_q      <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// The bank count is clamped to one through MAX_BANKS.
	logic [BCNT_W-1:0] eff_banks;
	always_comb begin
		eff_banks = bank_cnt_q;
		if (bank_cnt_q == '0) begin
			eff_banks = BCNT_W'(1);
		end else if (bank_cnt_q > BCNT_W'(MAX_BANKS)) begin
			eff_banks = BCNT_W'(MAX_BANKS);
		end
	end

	// Stage one holds the request while the table read completes.
	logic              s1_valid_q;
	logic [CMD_W-1:0]  cmd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [TS_W-1:0]   now_s1;
	logic [BANK_W-1:0] bank_s1;
	logic [WORD_W-1:0] st_s1;
	logic [WORD_W-1:0] addr_s1;

	logic accept;
	logic s1_done;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	// Only one request is in flight, so a table write never overlaps a read
	// of the same entry.
	assign s_tready = !s1_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign s1_done  = s1_valid_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= s_tdata[CMD_W-1:0];
			slot_s1 <= s_tdata[IN_CPU +: SLOT_W];
			now_s1  <= s_tdata[IN_NOW +: TS_W];
			bank_s1 <= s_tdata[IN_BANK +: BANK_W];
			st_s1   <= s_tdata[IN_ST +: WORD_W];
			addr_s1 <= s_tdata[IN_ADDR +: WORD_W];
		end
	end

	tbl_rd_t  tbl_rd;
	tbl_wr_t  tbl_wr;
	evt_upd_t evt_upd;
	evt_rec_t rec_next;

	mcbp_slot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (s_tdata[IN_CPU +: SLOT_W]),
		.rd      (tbl_rd),
		.wr      (tbl_wr)
	);

	mcbp_event_rec u_event (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (evt_upd),
		.rec_next (rec_next)
	);

	// Decide the action and the state updates once the table read has returned.
	logic [TS_W-1:0] elapsed;
	logic            too_soon;
	logic            bank_ok;
	act_t            action;

	assign elapsed  = now_s1 - tbl_rd.last_poll;
	assign too_soon = elapsed < {{(TS_W-GAP_W){1'b0}}, gap_q};
	assign bank_ok  = {1'b0, bank_s1} < eff_banks;

	always_comb begin
		action  = ACT_NONE;
		tbl_wr  = '0;
		evt_upd = '0;
		tbl_wr.addr    = slot_s1;
		tbl_wr.data    = now_s1;
		evt_upd.bank   = bank_s1;
		evt_upd.status = st_s1;
		evt_upd.addr   = st_s1[ST_ADDRV_BIT] ? addr_s1 : '0;
		evt_upd.uncorr = st_s1[ST_UC_BIT];
		evt_upd.over   = st_s1[ST_OVER_BIT];
		if (s1_done && mca_q) begin
			unique case (cmd_t'(cmd_s1))
				CMD_BEGIN: begin
					evt_upd.clear    = 1'b1;
					tbl_wr.clear_all = 1'b1;
				end
				CMD_POLL: begin
					if (!tbl_rd.baselined) begin
						tbl_wr.write = 1'b1;
						action       = ACT_CLRALL;
					end else if (throttle_q && too_soon) begin
						action = ACT_SKIP;
					end else begin
						tbl_wr.write = 1'b1;
						action       = ACT_SCAN;
					end
				end
				CMD_REPORT: begin
					if (bank_ok && st_s1[ST_VALID_BIT]) begin
						evt_upd.capture = 1'b1;
						action          = ACT_CLR1;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: the result shows the state after its request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			m_tdata_q <= {{(OUT_W-OUT_RAW_W){1'b0}},
				rec_next.over, rec_next.corr, rec_next.addr, rec_next.status,
				rec_next.bank, rec_next.captured, rec_next.uncorr_cnt,
				rec_next.corr_cnt, action};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Output field offsets used by the checks below.
	localparam int OUT_CC  = ACT_W;
	localparam int OUT_UC  = OUT_CC + CNT_W;
	localparam int OUT_HAS = OUT_UC + CNT_W;

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted request did not enter stage one");

	a_table_write_in_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(tbl_wr.write || tbl_wr.clear_all) |-> s1_done)
		else $error("table written outside a finishing request");

	a_clear_bank_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && action == ACT_CLR1) |=> m_tdata[OUT_HAS])
		else $error("clear-this-bank result without a captured event");

	a_begin_zeroes_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && evt_upd.clear) |=>
		(m_tdata[OUT_CC +: CNT_W] == '0 && m_tdata[OUT_UC +: CNT_W] == '0 &&
		 !m_tdata[OUT_HAS]))
		else $error("begin run did not clear the run record");

endmodule

// ===== design/mcbp_slot_table.sv =====
module mcbp_slot_table
	import mcbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output tbl_rd_t           rd,
	input  tbl_wr_t           wr
);

	logic [TS_W-1:0]      poll_mem [CPU_SLOTS];
	logic [CPU_SLOTS-1:0] baselined_q;
	logic [TS_W-1:0]      rd_poll_q;
	logic                 rd_base_q;

	// Poll times live in a synchronous memory; written entries only are ever used.
	always_ff @(posedge clk) begin
		if (wr.write) begin
			poll_mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_poll_q <= poll_mem[rd_addr];
		end
	end

	// Baselined marks are flops so that reset and a new run clear them at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baselined_q <= '0;
			rd_base_q   <= 1'b0;
		end else begin
			if (wr.clear_all) begin
				baselined_q <= '0;
			end else if (wr.write) begin
				baselined_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_base_q <= baselined_q[rd_addr];
			end
		end
	end

	assign rd.baselined = rd_base_q;
	assign rd.last_poll = rd_poll_q;

endmodule

// ===== design/mcbp_event_rec.sv =====
module mcbp_event_rec
	import mcbp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  evt_upd_t upd,
	output evt_rec_t rec_next
);

	evt_rec_t rec_q;

	always_comb begin
		rec_next = rec_q;
		if (upd.clear) begin
			rec_next = '0;
		end else if (upd.capture) begin
			if (upd.uncorr) begin
				rec_next.uncorr_cnt = rec_q.uncorr_cnt + CNT_W'(1);
			end else begin
				rec_next.corr_cnt = rec_q.corr_cnt + CNT_W'(1);
			end
			rec_next.captured = 1'b1;
			rec_next.bank     = upd.bank;
			rec_next.status   = upd.status;
			rec_next.addr     = upd.addr;
			rec_next.corr     = !upd.uncorr;
			rec_next.over     = upd.over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_next;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mcbp_pkg::*;

	// Command code 3 is not defined; the block must treat it as a no-op.
	localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

	// Status word flags.
	localparam logic [WORD_W-1:0] ST_VALID = 64'd1 << ST_VALID_BIT;
	localparam logic [WORD_W-1:0] ST_OVER  = 64'd1 << ST_OVER_BIT;
	localparam logic [WORD_W-1:0] ST_UC    = 64'd1 << ST_UC_BIT;
	localparam logic [WORD_W-1:0] ST_ADDRV = 64'd1 << ST_ADDRV_BIT;

	// Bit offsets of the result fields inside m_tdata, lowest field first.
	localparam int O_ACT  = 0;
	localparam int O_CORR = O_ACT + ACT_W;
	localparam int O_UNC  = O_CORR + CNT_W;
	localparam int O_HAS  = O_UNC + CNT_W;
	localparam int O_BANK = O_HAS + 1;
	localparam int O_STAT = O_BANK + BANK_W;
	localparam int O_ADDR = O_STAT + WORD_W;
	localparam int O_LCOR = O_ADDR + WORD_W;
	localparam int O_LOVR = O_LCOR + 1;

	// The run is stopped at this cycle count no matter what.
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CPU_W-1:0]  cpu;
		logic [TS_W-1:0]   now;
		logic [BANK_W-1:0] bank;
		logic [WORD_W-1:0] status;
		logic [WORD_W-1:0] addr;
	} mc_request_t;

	typedef struct packed {
		act_t              action;
		logic [CNT_W-1:0]  corr_cnt;
		logic [CNT_W-1:0]  uncorr_cnt;
		logic              has_last;
		logic [BANK_W-1:0] last_bank;
		logic [WORD_W-1:0] last_status;
		logic [WORD_W-1:0] last_addr;
		logic              last_corr;
		logic              last_over;
	} poll_result_t;

	logic                 clk;
	logic                 arst_n;
	logic [IN_W-1:0]      s_tdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	machine_check_bank_poller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the configuration registers, updated as they are written.
	logic              mca_on;
	logic [BCNT_W-1:0] bank_limit;
	logic              throttle_on;
	logic [GAP_W-1:0]  poll_gap;

	// Predicted state of the poller: per-CPU table and the run record.
	logic [CPU_SLOTS-1:0] slot_baselined;
	logic [TS_W-1:0]      slot_last_poll [CPU_SLOTS];
	logic [CNT_W-1:0]     corr_total;
	logic [CNT_W-1:0]     uncorr_total;
	logic                 ev_captured;
	logic [BANK_W-1:0]    ev_bank;
	logic [WORD_W-1:0]    ev_status;
	logic [WORD_W-1:0]    ev_addr;
	logic                 ev_corr;
	logic                 ev_over;

	// Per-CPU timestamp that the stimulus generator advances for poll requests.
	logic [TS_W-1:0] stim_clock [CPU_SLOTS];

	mc_request_t  request_queue[$];
	poll_result_t pending_results[$];
	mc_request_t  cur_req;
	logic         req_taken;
	logic         drain_hold;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           mismatch_count;
	int           cycle_count;

	always #10 clk = ~clk;

	// Number of banks in use after the clamp to 1 through MAX_BANKS.
	function automatic int clamped_banks();
		int n;
		n = int'(bank_limit);
		if (n < 1) n = 1;
		if (n > MAX_BANKS) n = MAX_BANKS;
		return n;
	endfunction

	// Applies one request to the predicted state and returns the result the
	// block must produce for it. The count and event fields always reflect the
	// state after the request has been handled.
	function automatic poll_result_t poller_next_result(mc_request_t r);
		poll_result_t res;
		int slot;
		logic corr;
		slot = int'(r.cpu) % CPU_SLOTS;
		res.action = ACT_NONE;
		if (mca_on) begin
			case (r.cmd)
				CMD_BEGIN: begin
					// A new run forgets counts, the last event and all baselines,
					// but keeps the stored poll times.
					corr_total = '0;
					uncorr_total = '0;
					ev_captured = 1'b0;
					ev_bank = '0;
					ev_status = '0;
					ev_addr = '0;
					ev_corr = 1'b0;
					ev_over = 1'b0;
					slot_baselined = '0;
				end
				CMD_POLL: begin
					if (!slot_baselined[slot]) begin
						// First poll on this CPU only clears the banks.
						slot_baselined[slot] = 1'b1;
						slot_last_poll[slot] = r.now;
						res.action = ACT_CLRALL;
					end else if (throttle_on &&
							(r.now - slot_last_poll[slot]) < {{(TS_W-GAP_W){1'b0}}, poll_gap}) begin
						// Elapsed time wraps modulo 2^64 by the 64-bit subtraction.
						res.action = ACT_SKIP;
					end else begin
						slot_last_poll[slot] = r.now;
						res.action = ACT_SCAN;
					end
				end
				CMD_REPORT: begin
					if (int'(r.bank) < clamped_banks() && r.status[ST_VALID_BIT]) begin
						corr = !r.status[ST_UC_BIT];
						if (corr) corr_total = corr_total + 1'b1;
						else uncorr_total = uncorr_total + 1'b1;
						ev_captured = 1'b1;
						ev_bank = r.bank;
						ev_status = r.status;
						ev_addr = r.status[ST_ADDRV_BIT] ? r.addr : '0;
						ev_corr = corr;
						ev_over = r.status[ST_OVER_BIT];
						res.action = ACT_CLR1;
					end
				end
				default: begin
				end
			endcase
		end
		res.corr_cnt = corr_total;
		res.uncorr_cnt = uncorr_total;
		res.has_last = ev_captured;
		res.last_bank = ev_captured ? ev_bank : '0;
		res.last_status = ev_captured ? ev_status : '0;
		res.last_addr = ev_captured ? ev_addr : '0;
		res.last_corr = ev_captured & ev_corr;
		res.last_over = ev_captured & ev_over;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Register writes happen only while the block is idle, one at a time, with cfg_we dropped between them.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MCA:      mca_on = val[0];
			CFG_BANKS:    bank_limit = val[BCNT_W-1:0];
			CFG_THROTTLE: throttle_on = val[0];
			CFG_GAP:      poll_gap = val[GAP_W-1:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [CPU_W-1:0] cpu,
			input logic [TS_W-1:0] now, input logic [BANK_W-1:0] bank,
			input logic [WORD_W-1:0] status, input logic [WORD_W-1:0] addr);
		mc_request_t r;
		r.cmd = cmd;
		r.cpu = cpu;
		r.now = now;
		r.bank = bank;
		r.status = status;
		r.addr = addr;
		request_queue.push_back(r);
	endtask

	// Random traffic shaped like real polling: polls, mostly on a handful of CPUs
	// with timestamps stepping around the throttle gap, and bank reports that
	// are mostly valid and in range. Begin-run, undefined commands, far-off CPUs
	// and out-of-range banks are mixed in as noise. Unused fields stay random.
	task automatic add_random_requests(input int count);
		mc_request_t r;
		int pick;
		logic [TS_W-1:0] step;
		logic [TS_W-1:0] gap64;
		gap64 = {{(TS_W-GAP_W){1'b0}}, poll_gap};
		for (int i = 0; i < count; i++) begin
			r.cpu = CPU_W'($urandom_range(0, 255));
			r.now = {$urandom, $urandom};
			r.bank = BANK_W'($urandom_range(0, 63));
			r.status = {$urandom, $urandom};
			r.addr = {$urandom, $urandom};
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				r.cmd = CMD_BEGIN;
			end else if (pick < 7) begin
				r.cmd = CMD_UNDEFINED;
			end else if (pick < 45) begin
				r.cmd = CMD_POLL;
				if ($urandom_range(0, 3) != 0) r.cpu = CPU_W'($urandom_range(0, 7));
				case ($urandom_range(0, 4))
					0: step = TS_W'($urandom_range(0, 255));
					1: step = gap64 - TS_W'($urandom_range(0, 2));
					2: step = gap64 + TS_W'($urandom_range(0, 2));
					3: step = {$urandom, $urandom};
					default: step = gap64 + TS_W'($urandom_range(0, 100000));
				endcase
				stim_clock[r.cpu] = stim_clock[r.cpu] + step;
				r.now = stim_clock[r.cpu];
			end else begin
				r.cmd = CMD_REPORT;
				if ($urandom_range(0, 4) != 0)
					r.bank = BANK_W'($urandom_range(0, clamped_banks() - 1));
				if ($urandom_range(0, 5) != 0) r.status[ST_VALID_BIT] = 1'b1;
			end
			request_queue.push_back(r);
		end
	endtask

	// Waits until every queued request has been taken and answered, then lets
	// the pipeline settle before any register is touched. The check runs at the
	// rising edge, where s_tvalid is stable and guards a request being taken.
	task automatic drain_phase();
		while (request_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Request driver: presents the next queued request at the falling edge once
	// the current one has been taken. Now and then it holds back until every
	// outstanding result has come out, so the block runs fully dry mid-phase.
	always @(negedge clk) begin
		logic [IN_W-1:0] pkt;
		pkt = '0;
		if (!s_tvalid || req_taken) begin
			if (drain_hold && pending_results.size() == 0) drain_hold = 1'b0;
			else if (!drain_hold && $urandom_range(0, 59) == 0) drain_hold = 1'b1;
			if (!drain_hold && request_queue.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				cur_req = request_queue.pop_front();
				pkt[IN_RAW_W-1:0] = {cur_req.addr, cur_req.status, cur_req.bank,
					cur_req.now, cur_req.cpu, cur_req.cmd};
				s_tdata <= pkt;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Prediction and result checking at the rising edge. A request is predicted
	// the moment it is taken; each result is matched against the oldest one.
	always @(posedge clk) begin
		poll_result_t want;
		req_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			pending_results.push_back(poller_next_result(cur_req));
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual action %0d",
					$time, m_tdata[O_ACT +: ACT_W]);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("action", 64'(want.action), 64'(m_tdata[O_ACT +: ACT_W]));
				compare_field("corrected_count", 64'(want.corr_cnt),
					64'(m_tdata[O_CORR +: CNT_W]));
				compare_field("uncorrected_count", 64'(want.uncorr_cnt),
					64'(m_tdata[O_UNC +: CNT_W]));
				compare_field("has_last", 64'(want.has_last), 64'(m_tdata[O_HAS]));
				compare_field("last_bank", 64'(want.last_bank),
					64'(m_tdata[O_BANK +: BANK_W]));
				compare_field("last_status", want.last_status, m_tdata[O_STAT +: WORD_W]);
				compare_field("last_addr", want.last_addr, m_tdata[O_ADDR +: WORD_W]);
				compare_field("last_corrected", 64'(want.last_corr), 64'(m_tdata[O_LCOR]));
				compare_field("last_overflow", 64'(want.last_over), 64'(m_tdata[O_LOVR]));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tdata = '0;
		s_tvalid = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MCA;
		cfg_data = '0;
		req_taken = 1'b0;
		drain_hold = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		cur_req = '0;

		// Register and state values after reset.
		mca_on = 1'b0;
		bank_limit = BCNT_W'(1);
		throttle_on = 1'b0;
		poll_gap = '0;
		slot_baselined = '0;
		corr_total = '0;
		uncorr_total = '0;
		ev_captured = 1'b0;
		ev_bank = '0;
		ev_status = '0;
		ev_addr = '0;
		ev_corr = 1'b0;
		ev_over = 1'b0;
		for (int i = 0; i < CPU_SLOTS; i++) begin
			slot_last_poll[i] = '0;
			stim_clock[i] = {$urandom, $urandom};
		end

		// First stretch: the sender idles lightly, the receiver heavily.
		send_idle_pct = 27;
		recv_idle_pct = 67;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// With machine check absent every request must come back as a no-op.
		queue_request(CMD_POLL, 8'd5, 64'd100, 6'd0, '0, '0);
		queue_request(CMD_REPORT, 8'd5, '0, 6'd0, ST_VALID | ST_ADDRV, '1);
		queue_request(CMD_BEGIN, 8'd0, '0, 6'd0, '0, '0);
		drain_phase();

		write_reg(CFG_MCA, CFG_W'(1));
		write_reg(CFG_BANKS, CFG_W'(4));
		write_reg(CFG_THROTTLE, CFG_W'(1));
		write_reg(CFG_GAP, CFG_W'(1000));

		// Directed walk through the poll decision and the report handling.
		queue_request(CMD_BEGIN, 8'd0, '0, 6'd0, '0, '0);
		// Unbaselined CPU, then inside the gap, then exactly at the gap.
		queue_request(CMD_POLL, 8'd0, 64'd100, 6'd0, '0, '0);
		queue_request(CMD_POLL, 8'd0, 64'd500, 6'd0, '0, '0);
		queue_request(CMD_POLL, 8'd0, 64'd1100, 6'd0, '0, '0);
		// Highest CPU with the timestamp wrapping past zero.
		queue_request(CMD_POLL, 8'd255, '1, 6'd63, '1, '1);
		queue_request(CMD_POLL, 8'd255, 64'd5, 6'd0, '0, '0);
		queue_request(CMD_POLL, 8'd255, 64'd2000, 6'd0, '0, '0);
		// Corrected error without a valid address: the address reads as zero.
		queue_request(CMD_REPORT, 8'd0, '0, 6'd0, ST_VALID, '1);
		// Uncorrected error with overflow and a valid address.
		queue_request(CMD_REPORT, 8'd1, '0, 6'd3, ST_VALID | ST_UC | ST_OVER | ST_ADDRV,
			64'hDEAD_BEEF_0123_4567);
		// Banks at or past the count in use are ignored.
		queue_request(CMD_REPORT, 8'd0, '0, 6'd4, ST_VALID, '1);
		queue_request(CMD_REPORT, 8'd0, '0, 6'd63, '1, '1);
		// Every status bit except valid: nothing is captured; with every bit set, it is.
		queue_request(CMD_REPORT, 8'd0, '0, 6'd1, ~ST_VALID, '1);
		queue_request(CMD_REPORT, 8'd255, '1, 6'd2, '1, '1);
		queue_request(CMD_UNDEFINED, 8'd255, '1, 6'd63, '1, '1);
		// A new run clears the baseline, so CPU 0 starts over with a bank clear.
		queue_request(CMD_BEGIN, 8'd0, '0, 6'd0, '0, '0);
		queue_request(CMD_POLL, 8'd0, 64'd0, 6'd0, '0, '0);
		drain_phase();

		// All banks in use and the largest gap.
		write_reg(CFG_BANKS, CFG_W'(64));
		write_reg(CFG_GAP, '1);
		add_random_requests(300);
		drain_phase();

		// Second stretch: the roles of the two sides are swapped.
		send_idle_pct = 67;
		recv_idle_pct = 27;
		write_reg(CFG_BANKS, CFG_W'(1));
		write_reg(CFG_THROTTLE, CFG_W'(0));
		write_reg(CFG_GAP, CFG_W'($urandom_range(1, 5000)));
		add_random_requests(300);
		drain_phase();

		// Third stretch at full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_BANKS, CFG_W'($urandom_range(2, 63)));
		write_reg(CFG_THROTTLE, CFG_W'(1));
		write_reg(CFG_GAP, CFG_W'(0));
		add_random_requests(150);
		drain_phase();

		// A bank count of zero is clamped up to one bank.
		write_reg(CFG_BANKS, CFG_W'(0));
		write_reg(CFG_GAP, CFG_W'($urandom_range(1, 100000)));
		add_random_requests(150);
		drain_phase();

		// Machine check switched off again: the run record must stay frozen.
		write_reg(CFG_MCA, CFG_W'(0));
		add_random_requests(20);
		drain_phase();

		// Any stray result in this window is caught by the checker.
		repeat (10) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== machine_check_bank_poller_top.f =====
design/mcbp_pkg.sv
design/mcbp_slot_table.sv
design/mcbp_event_rec.sv
design/machine_check_bank_poller_top.sv
verif/tb_top.sv
